FILE: sv/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg
// shared types and constants for the button debounce / auto-repeat core
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int unsigned NumButtons   = 5;
  localparam int unsigned TimeWidth    = 64;
  localparam int unsigned DebWidth     = 20;
  localparam int unsigned PeriodWidth  = 24;
  localparam int unsigned DelayWidth   = 24;
  localparam int unsigned CfgDataWidth = 24;
  localparam int unsigned CfgIdxWidth  = 2;

  localparam logic [DebWidth-1:0]    DebounceReset = DebWidth'(1000 * 5);
  localparam logic [PeriodWidth-1:0] PeriodReset   = PeriodWidth'(1000 * 200);
  localparam logic [DelayWidth-1:0]  DelayReset    = DelayWidth'(1000 * 300);

  // register indexes of the configuration port
  localparam logic [CfgIdxWidth-1:0] CfgDebounce = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgPeriod   = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgDelay    = 2'd2;

  typedef struct packed {
    logic [DebWidth-1:0]    debounce_time;
    logic [PeriodWidth-1:0] repeat_period;
    logic [DelayWidth-1:0]  initial_delay;
  } cfg_t;

  typedef struct packed {
    logic pressed;
    logic released;
    logic down;
    logic pulsed;
  } lane_res_t;

endpackage

FILE: sv/bda_lane.sv
// ----------------------------------------------------------------------------
// bda_lane
// per-button debounce and auto-repeat state, one scan per cycle while scans are accepted
// ----------------------------------------------------------------------------
module bda_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [bda_pkg::TimeWidth-1:0]     now_time_i,
  input  logic                              level_i,
  input  bda_pkg::cfg_t                     cfg_i,
  output bda_pkg::lane_res_t                res_o
);

  logic                          hold_valid_q, hold_valid_d;
  logic                          was_down_q, was_down_d;
  logic [bda_pkg::TimeWidth-1:0] hold_start_q, hold_start_d;
  logic [bda_pkg::TimeWidth-1:0] last_repeat_q, last_repeat_d;

  logic                          held;
  logic                          is_down;
  logic                          pulse;
  logic [bda_pkg::TimeWidth-1:0] start_eff;
  logic [bda_pkg::TimeWidth-1:0] hold_diff;
  logic [bda_pkg::TimeWidth-1:0] rep_diff;

  always_comb begin
    held      = ~level_i;
    // a fresh hold starts at the current scan
    start_eff = hold_valid_q ? hold_start_q : now_time_i;
    hold_diff = now_time_i - start_eff;
    is_down   = held &&
                (hold_diff > bda_pkg::TimeWidth'(cfg_i.debounce_time));
    rep_diff  = now_time_i - last_repeat_q;
    // signed compare: reference in the future never pulses
    pulse     = is_down && was_down_q && !rep_diff[bda_pkg::TimeWidth-1] &&
                (rep_diff > bda_pkg::TimeWidth'(cfg_i.repeat_period));

    hold_valid_d  = held;
    hold_start_d  = start_eff;
    was_down_d    = is_down;
    last_repeat_d = last_repeat_q;
    if (is_down && !was_down_q) begin
      last_repeat_d = now_time_i + bda_pkg::TimeWidth'(cfg_i.initial_delay);
    end else if (pulse) begin
      last_repeat_d = now_time_i;
    end

    res_o.pressed  = is_down && !was_down_q;
    res_o.released = !is_down && was_down_q;
    res_o.down     = is_down;
    res_o.pulsed   = pulse;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      was_down_q   <= 1'b0;
    end else if (accept_i) begin
      hold_valid_q <= hold_valid_d;
      was_down_q   <= was_down_d;
    end
  end

  // only read while hold_valid / was_down are set, so no reset needed
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      hold_start_q  <= hold_start_d;
      last_repeat_q <= last_repeat_d;
    end
  end

endmodule

FILE: sv/bda_merge.sv
// ----------------------------------------------------------------------------
// bda_merge
// gathers lane results into button masks and holds them in the output register
// ----------------------------------------------------------------------------
module bda_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  bda_pkg::lane_res_t [bda_pkg::NumButtons-1:0] lane_res_i,
  input  logic                                out_ready_i,
  output logic                                in_ready_o,
  output logic                                out_valid_o,
  output logic [bda_pkg::NumButtons-1:0]      pressed_mask_o,
  output logic [bda_pkg::NumButtons-1:0]      released_mask_o,
  output logic [bda_pkg::NumButtons-1:0]      down_mask_o,
  output logic [bda_pkg::NumButtons-1:0]      pulsed_mask_o
);

  logic                             out_valid_q, out_valid_d;
  logic [bda_pkg::NumButtons-1:0]   pressed_q, pressed_d;
  logic [bda_pkg::NumButtons-1:0]   released_q, released_d;
  logic [bda_pkg::NumButtons-1:0]   down_q, down_d;
  logic [bda_pkg::NumButtons-1:0]   pulsed_q, pulsed_d;

  always_comb begin
    for (int i = 0; i < bda_pkg::NumButtons; i++) begin
      pressed_d[i]  = lane_res_i[i].pressed;
      released_d[i] = lane_res_i[i].released;
      down_d[i]     = lane_res_i[i].down;
      pulsed_d[i]   = lane_res_i[i].pulsed;
    end
  end

  // a new request is taken whenever the slot is empty or drains this cycle
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign out_valid_d = accept_i || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pressed_q  <= pressed_d;
      released_q <= released_d;
      down_q     <= down_d;
      pulsed_q   <= pulsed_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pressed_mask_o  = pressed_q;
  assign released_mask_o = released_q;
  assign down_mask_o     = down_q;
  assign pulsed_mask_o   = pulsed_q;

endmodule

FILE: sv/button_debounce_autorepeat_core.sv
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_core
// debounce and auto-repeat for a bank of active-low buttons, one scan a request
// ----------------------------------------------------------------------------
// output: the result is registered, valid in the cycle after the request is accepted
// throughput: one scan per cycle unless the output register is held full, set by the
//   per-button state update (64-bit subtract and compare in each lane)
// reset: registers return to 5000 / 200000 / 300000 us, no button held or down,
//   output register empty
// ----------------------------------------------------------------------------
module button_debounce_autorepeat_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bda_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [bda_pkg::CfgDataWidth-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bda_pkg::TimeWidth-1:0]       now_time_i,
  input  logic [bda_pkg::NumButtons-1:0]      raw_levels_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bda_pkg::NumButtons-1:0]      pressed_mask_o,
  output logic [bda_pkg::NumButtons-1:0]      released_mask_o,
  output logic [bda_pkg::NumButtons-1:0]      down_mask_o,
  output logic [bda_pkg::NumButtons-1:0]      pulsed_mask_o
);

  bda_pkg::cfg_t cfg_q, cfg_d;
  logic          accept;
  bda_pkg::lane_res_t [bda_pkg::NumButtons-1:0] lane_res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        bda_pkg::CfgDebounce: cfg_d.debounce_time = cfg_wdata_i[bda_pkg::DebWidth-1:0];
        bda_pkg::CfgPeriod:   cfg_d.repeat_period = cfg_wdata_i[bda_pkg::PeriodWidth-1:0];
        bda_pkg::CfgDelay:    cfg_d.initial_delay = cfg_wdata_i[bda_pkg::DelayWidth-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time <= bda_pkg::DebounceReset;
      cfg_q.repeat_period <= bda_pkg::PeriodReset;
      cfg_q.initial_delay <= bda_pkg::DelayReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign accept = in_valid_i && in_ready_o;

  for (genvar g = 0; g < bda_pkg::NumButtons; g++) begin : g_lane
    bda_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .accept_i   (accept),
      .now_time_i (now_time_i),
      .level_i    (raw_levels_i[g]),
      .cfg_i      (cfg_q),
      .res_o      (lane_res[g])
    );
  end

  bda_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .lane_res_i      (lane_res),
    .out_ready_i     (out_ready_i),
    .in_ready_o      (in_ready_o),
    .out_valid_o     (out_valid_o),
    .pressed_mask_o  (pressed_mask_o),
    .released_mask_o (released_mask_o),
    .down_mask_o     (down_mask_o),
    .pulsed_mask_o   (pulsed_mask_o)
  );

endmodule

FILE: bench/button_debounce_autorepeat_core_test.sv
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_core_test
// Self-checking bench for the debounce / auto-repeat core. Scans are driven
// through the request handshake. Each accepted scan runs through an in-bench
// model of the per-button hold, debounce and repeat timers. Every returned
// result is compared mask by mask, in order, with the model's prediction.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // index past the last register, writes to it must be dropped
  localparam logic [bda_pkg::CfgIdxWidth-1:0] CfgNoReg = 2'd3;
  localparam int unsigned BtnIdxWidth = $clog2(bda_pkg::NumButtons);

  typedef logic [bda_pkg::TimeWidth-1:0]    usec_t;
  typedef logic [bda_pkg::NumButtons-1:0]   mask_t;
  typedef logic [bda_pkg::CfgDataWidth-1:0] cfg_word_t;
  typedef logic [BtnIdxWidth-1:0]           btn_idx_t;

  typedef struct packed {
    mask_t pressed;
    mask_t released;
    mask_t down;
    mask_t pulsed;
  } scan_res_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [bda_pkg::CfgIdxWidth-1:0]  cfg_index_i;
  logic [bda_pkg::CfgDataWidth-1:0] cfg_wdata_i;
  logic                             in_valid_i;
  logic                             in_ready_o;
  usec_t                            now_time_i;
  mask_t                            raw_levels_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  mask_t                            pressed_mask_o;
  mask_t                            released_mask_o;
  mask_t                            down_mask_o;
  mask_t                            pulsed_mask_o;

  button_debounce_autorepeat_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .now_time_i      (now_time_i),
    .raw_levels_i    (raw_levels_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pressed_mask_o  (pressed_mask_o),
    .released_mask_o (released_mask_o),
    .down_mask_o     (down_mask_o),
    .pulsed_mask_o   (pulsed_mask_o)
  );

  always #5 clk_i = ~clk_i;

  // model state
  logic [bda_pkg::DebWidth-1:0]    debounce_us;
  logic [bda_pkg::PeriodWidth-1:0] period_us;
  logic [bda_pkg::DelayWidth-1:0]  delay_us;
  usec_t                  hold_since [bda_pkg::NumButtons];
  bit                     holding    [bda_pkg::NumButtons];
  usec_t                  repeat_ref [bda_pkg::NumButtons];
  bit                     down_before[bda_pkg::NumButtons];

  scan_res_t pending_scans[$];

  int    error_count;
  int    scan_count;
  int    press_count;
  int    release_count;
  int    pulse_count;
  int    setting_count;

  bit    tx_idle;
  bit    rx_idle;
  int    rx_hold_left;
  int    rx_stall_left;

  // random button activity
  usec_t scan_time;
  mask_t level_now;
  int    level_run[bda_pkg::NumButtons];

  function automatic scan_res_t predict_scan(usec_t now, mask_t raw);
    scan_res_t res;
    usec_t     diff;
    bit        is_down;
    res = '0;
    for (int i = 0; i < bda_pkg::NumButtons; i++) begin
      if (!raw[i] && !holding[i]) begin
        hold_since[i] = now;
        holding[i]    = 1'b1;
      end else if (raw[i]) begin
        hold_since[i] = '0;
        holding[i]    = 1'b0;
      end
      is_down = holding[i] && ((now - hold_since[i]) > usec_t'(debounce_us));
      if (is_down) begin
        if (!down_before[i]) begin
          res.pressed[i] = 1'b1;
          repeat_ref[i]  = now + usec_t'(delay_us);
        end else begin
          // signed view keeps a future reference from firing
          diff = now - repeat_ref[i];
          if (!diff[bda_pkg::TimeWidth-1] && diff > usec_t'(period_us)) begin
            res.pulsed[i] = 1'b1;
            repeat_ref[i] = now;
          end
        end
        res.down[i] = 1'b1;
      end else begin
        if (down_before[i]) res.released[i] = 1'b1;
        repeat_ref[i] = '0;
      end
      down_before[i] = is_down;
    end
    scan_count++;
    press_count   += $countones(res.pressed);
    release_count += $countones(res.released);
    pulse_count   += $countones(res.pulsed);
    return res;
  endfunction

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_left--;
      end else if (rx_stall_left > 0) begin
        out_ready_i <= 1'b0;
        rx_stall_left--;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        out_ready_i   <= 1'b0;
        rx_stall_left = $urandom_range(0, 7);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    scan_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_scans.size() == 0) begin
        $error("result with no scan outstanding: pressed %b released %b down %b pulsed %b",
               pressed_mask_o, released_mask_o, down_mask_o, pulsed_mask_o);
        error_count++;
      end else begin
        want = pending_scans.pop_front();
        if (pressed_mask_o !== want.pressed) begin
          $error("pressed_mask: expected %b, actual %b", want.pressed, pressed_mask_o);
          error_count++;
        end
        if (released_mask_o !== want.released) begin
          $error("released_mask: expected %b, actual %b", want.released, released_mask_o);
          error_count++;
        end
        if (down_mask_o !== want.down) begin
          $error("down_mask: expected %b, actual %b", want.down, down_mask_o);
          error_count++;
        end
        if (pulsed_mask_o !== want.pulsed) begin
          $error("pulsed_mask: expected %b, actual %b", want.pulsed, pulsed_mask_o);
          error_count++;
        end
      end
    end
  end

  task automatic send_scan(usec_t now, mask_t raw);
    int gap;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    now_time_i   <= now;
    raw_levels_i <= raw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_scans.push_back(predict_scan(now, raw));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [bda_pkg::CfgIdxWidth-1:0] idx, cfg_word_t data);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bda_pkg::CfgDebounce: debounce_us = data[bda_pkg::DebWidth-1:0];
      bda_pkg::CfgPeriod:   period_us   = data[bda_pkg::PeriodWidth-1:0];
      bda_pkg::CfgDelay:    delay_us    = data[bda_pkg::DelayWidth-1:0];
      default:     ;
    endcase
    setting_count++;
  endtask

  task automatic set_timing(cfg_word_t deb, cfg_word_t per, cfg_word_t dly);
    write_reg(bda_pkg::CfgDebounce, deb);
    write_reg(bda_pkg::CfgPeriod, per);
    write_reg(bda_pkg::CfgDelay, dly);
  endtask

  function automatic usec_t next_time(int unsigned step_max);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) scan_time = scan_time - usec_t'($urandom_range(1, step_max));
    else if (pick < 3) scan_time = scan_time + {$urandom, $urandom};
    else scan_time = scan_time + usec_t'($urandom_range(0, step_max));
    return scan_time;
  endfunction

  // buttons hold a level for a run of scans, with the odd one-scan bounce or random mask
  function automatic mask_t next_raw();
    mask_t raw;
    for (int i = 0; i < bda_pkg::NumButtons; i++) begin
      if (level_run[i] == 0) begin
        level_now[i] = ~level_now[i];
        level_run[i] = $urandom_range(1, 40);
      end else begin
        level_run[i]--;
      end
    end
    raw = level_now;
    if ($urandom_range(0, 15) == 0) begin
      raw[btn_idx_t'($urandom_range(0, bda_pkg::NumButtons - 1))] ^= 1'b1;
    end
    if ($urandom_range(0, 30) == 0) raw = mask_t'($urandom);
    return raw;
  endfunction

  task automatic run_scans(int count, int unsigned step_max);
    usec_t now;
    for (int n = 0; n < count; n++) begin
      now = next_time(step_max);
      send_scan(now, next_raw());
    end
  endtask

  // reset timing: debounce edge, initial delay, repeat edge, partial release
  task automatic test_reset_timing();
    send_scan(64'd0, 5'h1F);
    send_scan(64'd10, 5'h00);
    send_scan(64'd5010, 5'h00);
    send_scan(64'd5011, 5'h00);
    send_scan(64'd100000, 5'h00);
    send_scan(64'd505011, 5'h00);
    send_scan(64'd505012, 5'h00);
    send_scan(64'd705013, 5'b10101);
    send_scan(64'd705013, 5'h1F);
  endtask

  // register truncation, zero period, time going backwards, 64-bit wrap
  task automatic test_timing_edges();
    usec_t t0;
    t0 = 64'h1_0000_0000;
    set_timing(24'hFFFFFF, 24'd0, 24'd0);
    send_scan(t0, 5'h1E);
    send_scan(t0 + 64'hF_FFFF, 5'h1E);
    send_scan(t0 + 64'h10_0000, 5'h1E);
    send_scan(t0 + 64'h10_0000, 5'h1E);
    send_scan(t0 + 64'h10_0001, 5'h1E);
    send_scan(t0 + 64'h10_0002, 5'h1F);
    write_reg(bda_pkg::CfgDebounce, 24'd0);
    write_reg(CfgNoReg, 24'hFFFFFF);
    send_scan(64'd1000, 5'h0F);
    send_scan(64'd999, 5'h0F);
    write_reg(bda_pkg::CfgPeriod, 24'hFFFFFF);
    write_reg(bda_pkg::CfgDelay, 24'hFFFFFF);
    send_scan(64'hFFFF_FFFF_FFFF_FFFD, 5'h1B);
    send_scan(64'hFFFF_FFFF_FFFF_FFFF, 5'h1B);
    send_scan(64'h0000_0000_01FF_FFFE, 5'h1B);
    send_scan(64'h0000_0000_01FF_FFFF, 5'h1F);
  endtask

  task automatic test_random_short_timing();
    for (int p = 0; p < 3; p++) begin
      set_timing(cfg_word_t'($urandom_range(0, 20)), cfg_word_t'($urandom_range(0, 30)),
                 cfg_word_t'($urandom_range(0, 60)));
      scan_time = {$urandom, $urandom};
      run_scans(120, 8);
    end
  endtask

  task automatic test_random_zero_timing();
    set_timing(24'd0, 24'd0, 24'd0);
    scan_time = 64'hFFFF_FFFF_FFFF_FFFF - usec_t'($urandom_range(0, 400));
    run_scans(250, 3);
  endtask

  task automatic test_random_max_timing();
    set_timing(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    scan_time = {$urandom, $urandom};
    run_scans(250, 1 << 22);
  endtask

  // hold the result side off while scans keep coming, so the input stalls
  task automatic test_output_hold_off();
    set_timing(cfg_word_t'($urandom_range(0, 10)), cfg_word_t'($urandom_range(0, 20)),
               cfg_word_t'($urandom_range(0, 30)));
    scan_time = {$urandom, $urandom};
    run_scans(20, 6);
    tx_idle      = 1'b0;
    rx_hold_left = 300;
    run_scans(180, 6);
    tx_idle = 1'b1;
  endtask

  task automatic test_reset_timing_no_idle();
    set_timing(cfg_word_t'(bda_pkg::DebounceReset), cfg_word_t'(bda_pkg::PeriodReset),
               cfg_word_t'(bda_pkg::DelayReset));
    tx_idle   = 1'b0;
    rx_idle   = 1'b0;
    scan_time = {$urandom, $urandom};
    run_scans(300, 40000);
  endtask

  initial begin
    #5_000_000;
    $display("button_debounce_autorepeat_core_test: done, errors");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    now_time_i   = '0;
    raw_levels_i = '1;
    debounce_us  = bda_pkg::DebounceReset;
    period_us    = bda_pkg::PeriodReset;
    delay_us     = bda_pkg::DelayReset;
    for (int i = 0; i < bda_pkg::NumButtons; i++) begin
      hold_since[i]  = '0;
      holding[i]     = 1'b0;
      repeat_ref[i]  = '0;
      down_before[i] = 1'b0;
      level_run[i]   = $urandom_range(0, 20);
    end
    level_now     = '1;
    error_count   = 0;
    scan_count    = 0;
    press_count   = 0;
    release_count = 0;
    pulse_count   = 0;
    setting_count = 0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    rx_hold_left  = 0;
    rx_stall_left = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_timing();
    test_timing_edges();
    test_random_short_timing();
    test_random_zero_timing();
    test_random_max_timing();
    test_output_hold_off();
    test_reset_timing_no_idle();

    wait_idle();
    repeat (5) @(posedge clk_i);
    $display("checked %0d scans over %0d register writes", scan_count, setting_count);
    $display("seen %0d presses, %0d releases, %0d repeat pulses",
             press_count, release_count, pulse_count);
    if (error_count == 0) begin
      $display("button_debounce_autorepeat_core_test: done, clean");
    end else begin
      $display("button_debounce_autorepeat_core_test: done, errors");
    end
    $finish;
  end

endmodule
